### hdl/iremq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed removal queue package
// Shared widths, request and status codes, defaults and the cell control type.
// ----------------------------------------------------------------------------
package iremq_pkg;

  localparam int VALUE_W  = 32;
  localparam int POS_W    = 16;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  localparam int DEPTH_DEF = 256;
  localparam int GROUP_DEF = 16;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TAKE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic append;
    logic take;
  } iremq_ctl_t;

endpackage
`default_nettype wire

### hdl/iremq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed removal queue cell
// Holds one entry; loads an appended value or moves up its neighbor's entry.
// ----------------------------------------------------------------------------
module iremq_cell import iremq_pkg::*; #(
  parameter int IDX_W = 8,
  parameter int INDEX = 0
) (
  input  wire logic               clk,
  input  wire iremq_ctl_t         ctl,
  input  wire logic [IDX_W-1:0]   wr_index,
  input  wire logic [IDX_W-1:0]   take_index,
  input  wire logic [VALUE_W-1:0] value_in,
  input  wire logic [VALUE_W-1:0] neighbor_in,
  output logic [VALUE_W-1:0]      data_out,
  output logic                    hit
);

  localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

  logic [VALUE_W-1:0] data;

  always_ff @(posedge clk) begin
    if (ctl.take && (MY_INDEX >= take_index)) begin
      data <= neighbor_in;
    end else if (ctl.append && (MY_INDEX == wr_index)) begin
      data <= value_in;
    end
  end

  assign data_out = data;
  assign hit      = ctl.take && (MY_INDEX == take_index);

endmodule
`default_nettype wire

### hdl/iremq_gather.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed removal queue gather
// Picks the entry of the hit cell through a registered two-level OR tree.
// ----------------------------------------------------------------------------
module iremq_gather import iremq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int GROUP = GROUP_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          capture,
  input  wire logic [DEPTH-1:0][VALUE_W-1:0] cell_data,
  input  wire logic [DEPTH-1:0]              cell_hit,
  output logic [VALUE_W-1:0]                 taken
);

  localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;

  logic [NGROUPS-1:0][VALUE_W-1:0] part;
  logic [NGROUPS-1:0][VALUE_W-1:0] part_next;

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      part_next[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < DEPTH) begin
          if (cell_hit[g * GROUP + j]) begin
            part_next[g] = part_next[g] | cell_data[g * GROUP + j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      part <= part_next;
    end
  end

  always_comb begin
    taken = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      taken = taken | part[g];
    end
  end

endmodule
`default_nettype wire

### hdl/indexed_removal_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed removal queue
// An ordered list of signed values with append, take by position and clear.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (req_type, value, position) under
// in_valid and in_ready. Every request returns exactly one item on the output
// channel (status, taken_value, entry_count) under out_valid and out_ready.
// The entries live in a row of cells. On a take, every cell at or after the
// taken position loads its neighbor's entry, so the gap closes.
// Append, clear and a take that finds no entry answer in the cycle after
// acceptance. A successful take answers after its collect state, because
// the removed entry is collected through a registered OR tree over groups of
// cells. A new item is accepted when no take is in progress and the output
// register is free or being emptied in the same cycle, so the block takes one
// item per cycle if the receiver keeps up, pausing after each successful take.
// While the receiver stalls, the result stays in the output register and no
// new item is accepted. Reset empties the list and drops any pending result.
// ----------------------------------------------------------------------------
module indexed_removal_queue import iremq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int GROUP = GROUP_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [REQ_W-1:0]           req_type,
  input  wire logic signed [VALUE_W-1:0]  value,
  input  wire logic [POS_W-1:0]           position,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [STATUS_W-1:0]             status,
  output logic signed [VALUE_W-1:0]       taken_value,
  output logic [COUNT_W-1:0]              entry_count
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_TAKE = 1'b1;

  logic             state;
  logic [CNT_W-1:0] count;

  logic             accept;
  logic             full;
  logic             take_ok;
  logic [POS_W-1:0] pos_m1;
  logic [31:0]      count_ext;
  logic [CNT_W-1:0] count_next;
  iremq_ctl_t       ctl;

  logic [DEPTH-1:0][VALUE_W-1:0] cell_data;
  logic [DEPTH-1:0]              cell_hit;
  logic [VALUE_W-1:0]            gathered;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign take_ok   = (position != '0) && (32'(position) <= 32'(count));
  assign pos_m1    = position - POS_W'(1);

  assign ctl.take   = accept && (req_type == REQ_TAKE) && take_ok;
  assign ctl.append = accept && (req_type != REQ_TAKE) && (req_type != REQ_CLEAR) && !full;

  always_comb begin
    count_next = count;
    if (ctl.take) begin
      count_next = count - CNT_W'(1);
    end else if (ctl.append) begin
      count_next = count + CNT_W'(1);
    end else if (accept && (req_type == REQ_CLEAR)) begin
      count_next = '0;
    end
  end

  assign count_ext = 32'(count_next);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    iremq_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .wr_index    (count[IDX_W-1:0]),
      .take_index  (pos_m1[IDX_W-1:0]),
      .value_in    (value),
      .neighbor_in ((i < DEPTH - 1) ? cell_data[(i < DEPTH - 1) ? i + 1 : i] : cell_data[i]),
      .data_out    (cell_data[i]),
      .hit         (cell_hit[i])
    );
  end

  iremq_gather #(
    .DEPTH (DEPTH),
    .GROUP (GROUP)
  ) u_gather (
    .clk       (clk),
    .capture   (ctl.take),
    .cell_data (cell_data),
    .cell_hit  (cell_hit),
    .taken     (gathered)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (ctl.take) begin
              state <= S_TAKE;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        S_TAKE: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_TAKE) begin
      status      <= ST_TAKEN;
      taken_value <= gathered;
    end else if (accept) begin
      taken_value <= '0;
      entry_count <= count_ext[COUNT_W-1:0];
      if (req_type == REQ_TAKE) begin
        status <= ST_NONE;
      end else if (req_type == REQ_CLEAR) begin
        status <= ST_CLEARED;
      end else if (full) begin
        status <= ST_FULL;
      end else begin
        status <= ST_APPENDED;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) 32'(count) <= 32'(DEPTH))
    else $error("entry count exceeds the depth");

  assert property (@(posedge clk) disable iff (rst) (state == S_TAKE) |-> !out_valid)
    else $error("result pending while a take is in progress");

  assert property (@(posedge clk) disable iff (rst) ctl.take |=> (state == S_TAKE))
    else $error("successful take did not enter the collect cycle");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_TAKEN)) |-> (taken_value == '0))
    else $error("taken value is nonzero for a result that removed nothing");

endmodule
`default_nettype wire
